### rtl/core/plbcd_pkg.sv
package plbcd_pkg;

    localparam int ENTRIES     = 64;
    localparam int BLOCK_BYTES = 512;
    localparam int PIN_BITS    = 8;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int OFS_W  = $clog2(BLOCK_BYTES);
    localparam int POS_W  = 64;
    localparam int BLK_W  = 55;
    localparam int SLOT_W = 6;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;

    localparam logic [PIN_BITS-1:0] PIN_MAX  = '1;
    localparam logic [CNT_W-1:0]    CNT_FULL = CNT_W'(ENTRIES);

    localparam logic [OP_W-1:0] OP_GET     = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_MISS     = 2'd1;
    localparam logic [ST_W-1:0] ST_BUSY     = 2'd2;
    localparam logic [ST_W-1:0] ST_MISALIGN = 2'd3;

    typedef enum logic [2:0] {
        CMD_GET,
        CMD_MISALIGN,
        CMD_RELEASE,
        CMD_FLUSH,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [BLK_W-1:0]   blk;
        logic [SLOT_W-1:0]  slot;
        logic               dirty;
    } cmd_t;

    typedef struct packed {
        logic [BLK_W-1:0]    blk;
        logic                dirty;
        logic [PIN_BITS-1:0] pins;
        logic [IDX_W-1:0]    rank;
    } ent_t;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [SLOT_W-1:0] slot;
        logic              fetch;
        logic              wb;
        logic [BLK_W-1:0]  wb_blk;
        logic              last;
    } res_t;

    localparam int ENT_W = $bits(ent_t);

endpackage

### rtl/core/plbcd_ram.sv
module plbcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/plbcd_front.sv
module plbcd_front
    import plbcd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [OP_W-1:0]   s_operation,
    input  logic [POS_W-1:0]  s_position,
    input  logic [SLOT_W-1:0] s_slot,
    input  logic              s_dirty_mark,
    output logic              cmd_valid,
    output cmd_t              cmd,
    input  logic              cmd_pop
);

    cmd_t       q_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    cmd_t       dec;

    // classify the incoming transaction
    always_comb begin
        dec.blk   = s_position[OFS_W +: BLK_W];
        dec.slot  = s_slot;
        dec.dirty = s_dirty_mark;
        unique case (s_operation)
            OP_GET:     dec.kind = (|s_position[OFS_W-1:0]) ? CMD_MISALIGN : CMD_GET;
            OP_RELEASE: dec.kind = CMD_RELEASE;
            OP_FLUSH:   dec.kind = CMD_FLUSH;
            default:    dec.kind = CMD_NOP;
        endcase
    end

    assign s_ready   = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_pop && cmd_valid;

    always_comb begin
        wr_next  = push ? !wr_reg : wr_reg;
        rd_next  = pop ? !rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            q_reg[wr_reg] <= dec;
        end
    end

endmodule

### rtl/core/plbcd_back.sv
module plbcd_back
    import plbcd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_pop,
    input  logic m_ready,
    output logic m_valid,
    output res_t m_res
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_PROMO,
        S_REL_WR,
        S_FL_SCAN,
        S_FL_STEP,
        S_FL_ORD,
        S_FL_CHK,
        S_EMIT
    } state_t;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                pv_reg, pv_next;
    logic [IDX_W-1:0]    pidx_reg, pidx_next;
    logic                hit_f_reg, hit_f_next;
    logic [IDX_W-1:0]    hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]    hit_rank_reg, hit_rank_next;
    logic                free_f_reg, free_f_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic                vic_f_reg, vic_f_next;
    logic [IDX_W-1:0]    vic_idx_reg, vic_idx_next;
    logic [IDX_W-1:0]    vic_rank_reg, vic_rank_next;
    logic                vic_dirty_reg, vic_dirty_next;
    logic [BLK_W-1:0]    vic_blk_reg, vic_blk_next;
    logic                is_hit_reg, is_hit_next;
    logic [IDX_W-1:0]    tgt_reg, tgt_next;
    logic [CNT_W-1:0]    limit_reg, limit_next;
    logic [ENTRIES-1:0]  valid_reg, valid_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    rptr_reg, rptr_next;
    logic                prev_f_reg, prev_f_next;
    logic [IDX_W-1:0]    prev_idx_reg, prev_idx_next;
    logic [BLK_W-1:0]    prev_blk_reg, prev_blk_next;
    logic [IDX_W-1:0]    fidx_reg, fidx_next;
    res_t                res_reg, res_next;
    logic                m_valid_reg, m_valid_next;
    res_t                m_res_reg, m_res_next;

    logic                ent_we, ent_re;
    logic [IDX_W-1:0]    ent_waddr, ent_raddr;
    ent_t                ent_wdata, ent_rd;
    logic [ENT_W-1:0]    ent_rdata;
    logic                ord_we, ord_re;
    logic [IDX_W-1:0]    ord_waddr, ord_raddr, ord_wdata, ord_rdata;
    logic                scan_done, rel_ok;
    logic [IDX_W-1:0]    rel_idx;

    plbcd_ram #(.WIDTH(ENT_W), .DEPTH(ENTRIES)) u_ent_ram (
        .aclk  (aclk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .re    (ent_re),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    // rank to entry map, rebuilt at the start of each flush
    plbcd_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_ord_ram (
        .aclk  (aclk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .re    (ord_re),
        .raddr (ord_raddr),
        .rdata (ord_rdata)
    );

    assign ent_rd    = ent_t'(ent_rdata);
    assign scan_done = (cnt_reg == CNT_FULL) && !pv_reg;
    assign rel_idx   = IDX_W'(cmd.slot);
    assign rel_ok    = (32'(cmd.slot) < ENTRIES) && valid_reg[rel_idx];
    assign cmd_pop   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_res     = m_res_reg;

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        cnt_next       = cnt_reg;
        pv_next        = 1'b0;
        pidx_next      = pidx_reg;
        hit_f_next     = hit_f_reg;
        hit_idx_next   = hit_idx_reg;
        hit_rank_next  = hit_rank_reg;
        free_f_next    = free_f_reg;
        free_idx_next  = free_idx_reg;
        vic_f_next     = vic_f_reg;
        vic_idx_next   = vic_idx_reg;
        vic_rank_next  = vic_rank_reg;
        vic_dirty_next = vic_dirty_reg;
        vic_blk_next   = vic_blk_reg;
        is_hit_next    = is_hit_reg;
        tgt_next       = tgt_reg;
        limit_next     = limit_reg;
        valid_next     = valid_reg;
        count_next     = count_reg;
        rptr_next      = rptr_reg;
        prev_f_next    = prev_f_reg;
        prev_idx_next  = prev_idx_reg;
        prev_blk_next  = prev_blk_reg;
        fidx_next      = fidx_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_res_next     = m_res_reg;
        ent_we         = 1'b0;
        ent_waddr      = pidx_reg;
        ent_wdata      = ent_rd;
        ent_re         = 1'b0;
        ent_raddr      = cnt_reg[IDX_W-1:0];
        ord_we         = 1'b0;
        ord_waddr      = ent_rd.rank;
        ord_wdata      = pidx_reg;
        ord_re         = 1'b0;
        ord_raddr      = rptr_reg[IDX_W-1:0];

        // sweep the entry memory one address a cycle
        if (state_reg == S_SCAN || state_reg == S_PROMO || state_reg == S_FL_SCAN) begin
            if (cnt_reg != CNT_FULL) begin
                ent_re    = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                pv_next   = 1'b1;
                pidx_next = cnt_reg[IDX_W-1:0];
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                cmd_next   = cmd;
                cnt_next   = '0;
                hit_f_next = 1'b0;
                free_f_next = 1'b0;
                vic_f_next = 1'b0;
                res_next   = '0;
                res_next.last = 1'b1;
                if (cmd_valid) begin
                    unique case (cmd.kind)
                        CMD_GET:      state_next = S_SCAN;
                        CMD_MISALIGN: begin
                            res_next.status = ST_MISALIGN;
                            state_next      = S_EMIT;
                        end
                        CMD_RELEASE: begin
                            res_next.slot = cmd.slot;
                            if (rel_ok) begin
                                ent_re     = 1'b1;
                                ent_raddr  = rel_idx;
                                state_next = S_REL_WR;
                            end else begin
                                state_next = S_EMIT;
                            end
                        end
                        CMD_FLUSH:    state_next = S_FL_SCAN;
                        default:      state_next = S_EMIT;
                    endcase
                end
            end
            S_SCAN: begin
                if (pv_reg) begin
                    if (valid_reg[pidx_reg] && ent_rd.blk == cmd_reg.blk && !hit_f_reg) begin
                        hit_f_next    = 1'b1;
                        hit_idx_next  = pidx_reg;
                        hit_rank_next = ent_rd.rank;
                    end
                    if (!valid_reg[pidx_reg] && !free_f_reg) begin
                        free_f_next   = 1'b1;
                        free_idx_next = pidx_reg;
                    end
                    if (valid_reg[pidx_reg] && ent_rd.pins == '0
                        && (!vic_f_reg || ent_rd.rank > vic_rank_reg)) begin
                        vic_f_next     = 1'b1;
                        vic_idx_next   = pidx_reg;
                        vic_rank_next  = ent_rd.rank;
                        vic_dirty_next = ent_rd.dirty;
                        vic_blk_next   = ent_rd.blk;
                    end
                end
                if (scan_done) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                cnt_next    = '0;
                is_hit_next = hit_f_reg;
                state_next  = S_PROMO;
                priority if (hit_f_reg) begin
                    tgt_next        = hit_idx_reg;
                    limit_next      = CNT_W'(hit_rank_reg);
                    res_next.slot   = SLOT_W'(hit_idx_reg);
                end else if (free_f_reg) begin
                    tgt_next        = free_idx_reg;
                    limit_next      = CNT_FULL;
                    valid_next[free_idx_reg] = 1'b1;
                    count_next      = count_reg + 1'b1;
                    res_next.status = ST_MISS;
                    res_next.slot   = SLOT_W'(free_idx_reg);
                    res_next.fetch  = 1'b1;
                end else if (vic_f_reg) begin
                    tgt_next        = vic_idx_reg;
                    limit_next      = CNT_W'(vic_rank_reg);
                    res_next.status = ST_MISS;
                    res_next.slot   = SLOT_W'(vic_idx_reg);
                    res_next.fetch  = 1'b1;
                    res_next.wb     = vic_dirty_reg;
                    res_next.wb_blk = vic_dirty_reg ? vic_blk_reg : '0;
                end else begin
                    res_next.status = ST_BUSY;
                    state_next      = S_EMIT;
                end
            end
            S_PROMO: begin
                if (pv_reg) begin
                    ent_we = 1'b1;
                    if (pidx_reg == tgt_reg) begin
                        ent_wdata.rank = '0;
                        if (is_hit_reg) begin
                            ent_wdata.pins = (ent_rd.pins == PIN_MAX) ? ent_rd.pins
                                                                      : ent_rd.pins + 1'b1;
                        end else begin
                            ent_wdata.blk   = cmd_reg.blk;
                            ent_wdata.dirty = 1'b0;
                            ent_wdata.pins  = PIN_BITS'(1);
                        end
                    end else if (valid_reg[pidx_reg] && CNT_W'(ent_rd.rank) < limit_reg) begin
                        ent_wdata.rank = ent_rd.rank + 1'b1;
                    end
                end
                if (scan_done) begin
                    state_next = S_EMIT;
                end
            end
            S_REL_WR: begin
                ent_we    = 1'b1;
                ent_waddr = IDX_W'(cmd_reg.slot);
                ent_wdata.dirty = ent_rd.dirty | cmd_reg.dirty;
                ent_wdata.pins  = (ent_rd.pins == '0) ? ent_rd.pins : ent_rd.pins - 1'b1;
                state_next = S_EMIT;
            end
            S_FL_SCAN: begin
                if (pv_reg && valid_reg[pidx_reg]) begin
                    ord_we = 1'b1;
                end
                if (scan_done) begin
                    rptr_next   = '0;
                    prev_f_next = 1'b0;
                    state_next  = S_FL_STEP;
                end
            end
            S_FL_STEP: begin
                if (rptr_reg == count_reg || rptr_reg == CNT_FULL) begin
                    res_next      = '0;
                    res_next.last = 1'b1;
                    if (prev_f_reg) begin
                        res_next.slot   = SLOT_W'(prev_idx_reg);
                        res_next.wb     = 1'b1;
                        res_next.wb_blk = prev_blk_reg;
                    end
                    state_next = S_EMIT;
                end else begin
                    ord_re     = 1'b1;
                    state_next = S_FL_ORD;
                end
            end
            S_FL_ORD: begin
                ent_re     = 1'b1;
                ent_raddr  = ord_rdata;
                fidx_next  = ord_rdata;
                state_next = S_FL_CHK;
            end
            S_FL_CHK: begin
                rptr_next  = rptr_reg + 1'b1;
                state_next = S_FL_STEP;
                if (ent_rd.dirty) begin
                    ent_we          = 1'b1;
                    ent_waddr       = fidx_reg;
                    ent_wdata.dirty = 1'b0;
                    prev_f_next     = 1'b1;
                    prev_idx_next   = fidx_reg;
                    prev_blk_next   = ent_rd.blk;
                    if (prev_f_reg) begin
                        res_next        = '0;
                        res_next.slot   = SLOT_W'(prev_idx_reg);
                        res_next.wb     = 1'b1;
                        res_next.wb_blk = prev_blk_reg;
                        state_next      = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_res_next   = res_reg;
                    state_next   = res_reg.last ? S_IDLE : S_FL_STEP;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pv_reg      <= 1'b0;
            valid_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pv_reg      <= pv_next;
            valid_reg   <= valid_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg       <= cmd_next;
        cnt_reg       <= cnt_next;
        pidx_reg      <= pidx_next;
        hit_f_reg     <= hit_f_next;
        hit_idx_reg   <= hit_idx_next;
        hit_rank_reg  <= hit_rank_next;
        free_f_reg    <= free_f_next;
        free_idx_reg  <= free_idx_next;
        vic_f_reg     <= vic_f_next;
        vic_idx_reg   <= vic_idx_next;
        vic_rank_reg  <= vic_rank_next;
        vic_dirty_reg <= vic_dirty_next;
        vic_blk_reg   <= vic_blk_next;
        is_hit_reg    <= is_hit_next;
        tgt_reg       <= tgt_next;
        limit_reg     <= limit_next;
        rptr_reg      <= rptr_next;
        prev_f_reg    <= prev_f_next;
        prev_idx_reg  <= prev_idx_next;
        prev_blk_reg  <= prev_blk_next;
        fidx_reg      <= fidx_next;
        res_reg       <= res_next;
        m_res_reg     <= m_res_next;
    end

endmodule

### rtl/core/pinned_lru_block_cache_directory.sv
// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  operation, position, slot, dirty_mark
// m_        out        m_valid / m_ready  status, result_slot, fetch_valid,
//                                         writeback_valid, writeback_block, last
// get: two sweeps of the entry memory, scan then promote; busy: the scan sweep only
// release: at most one read and one write of the entry memory; misaligned or unknown requests: no access
// flush: one sweep to rebuild the rank map, then per valid entry S_FL_STEP, S_FL_ORD, S_FL_CHK, plus S_EMIT per result
// reset (aresetn low, synchronous) clears all valid bits, no clearing pass
// a two-deep input queue keeps taking transactions while the back end or m_ready stalls, until it is full
module pinned_lru_block_cache_directory
    import plbcd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [OP_W-1:0]   s_operation,
    input  logic [POS_W-1:0]  s_position,
    input  logic [SLOT_W-1:0] s_slot,
    input  logic              s_dirty_mark,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ST_W-1:0]   m_status,
    output logic [SLOT_W-1:0] m_result_slot,
    output logic              m_fetch_valid,
    output logic              m_writeback_valid,
    output logic [BLK_W-1:0]  m_writeback_block,
    output logic              m_last
);

    logic cmd_valid, cmd_pop;
    cmd_t cmd;
    res_t res;

    plbcd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_position   (s_position),
        .s_slot       (s_slot),
        .s_dirty_mark (s_dirty_mark),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop)
    );

    plbcd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_res     (res)
    );

    assign m_status          = res.status;
    assign m_result_slot     = res.slot;
    assign m_fetch_valid     = res.fetch;
    assign m_writeback_valid = res.wb;
    assign m_writeback_block = res.wb_blk;
    assign m_last            = res.last;

endmodule

### rtl/core/plbcd_checker.sv
module plbcd_checker
    import plbcd_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [ST_W-1:0]   m_status,
    input logic [SLOT_W-1:0] m_result_slot,
    input logic              m_fetch_valid,
    input logic              m_writeback_valid,
    input logic [BLK_W-1:0]  m_writeback_block,
    input logic              m_last
);

    // stalled result stays valid, with writeback block and last held
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_writeback_block) && $stable(m_last))
        else $error("result dropped while stalled");

    // fetch only on a miss, which is always the only result
    a_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_fetch_valid |-> m_status == ST_MISS && m_last)
        else $error("fetch without miss");

    // refused gets carry nothing
    a_refused: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_BUSY || m_status == ST_MISALIGN)
        |-> m_last && !m_fetch_valid && !m_writeback_valid && m_result_slot == '0)
        else $error("busy or misaligned result not empty");

    // no block number without a write-back
    a_wb_blk: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_writeback_valid |-> m_writeback_block == '0)
        else $error("stray write-back block");

endmodule

bind pinned_lru_block_cache_directory plbcd_checker u_plbcd_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_status          (m_status),
    .m_result_slot     (m_result_slot),
    .m_fetch_valid     (m_fetch_valid),
    .m_writeback_valid (m_writeback_valid),
    .m_writeback_block (m_writeback_block),
    .m_last            (m_last)
);
